// File: sv/fuzzy_word_search_unit_assert.svh
// assertion macros for the fuzzy word search unit
// included by the top level; no other dependencies
`ifndef FUZZY_WORD_SEARCH_UNIT_ASSERT_SVH
`define FUZZY_WORD_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FWS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fws assertion failed");
`define FWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error("fws assertion failed");
`else
`define FWS_ASSERT_IMPL(label, clk, rst_n, prop)
`define FWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/fws_pkg.sv
// shared types, constants and helpers for the fuzzy word search unit
// no dependencies
package fws_pkg;
    localparam int NEEDLE_MAX = 32;
    localparam int DW = 6;
    localparam int LW = $clog2(NEEDLE_MAX + 1);

    typedef enum logic [2:0] {
        REG_NEEDLE_LO     = 3'd0,
        REG_NEEDLE_MID_LO = 3'd1,
        REG_NEEDLE_MID_HI = 3'd2,
        REG_NEEDLE_HI     = 3'd3,
        REG_NEEDLE_LEN    = 3'd4,
        REG_GOOD          = 3'd5,
        REG_STRICT        = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // one control beat into the cell row
    typedef struct packed {
        logic       valid;
        logic       start;
        logic [7:0] ch;
    } cell_ctl_t;

    function automatic logic is_delim(input logic [7:0] c);
        return c inside {8'h20, 8'h2c, 8'h2e, 8'h3b, 8'h2d, 8'h0a, 8'h00};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h41:8'h5a]}) || (c inside {[8'h61:8'h7a]});
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5a]}) ? c + 8'd32 : c;
    endfunction
endpackage

// File: sv/fws_stream_if.sv
// valid/ready channel carrying a generic payload
// depends on nothing
interface fws_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/fuzzy_word_search_unit.sv
// fuzzy word search unit: Levenshtein word search over a byte stream
// channel in: valid/ready carrying {last_byte, text_byte}; channel out: one result
// per text, on its last byte. config: write enable, index, 64-bit data.
// each word byte enters a row of 32 needle cells; the wavefront is skewed, so
// the byte reaches each cell through the control register of every cell before
// it. a scored byte is accepted, then the row drains while a counter loaded
// with n (n = needle_length capped at 32) counts down, since the next byte of
// a word needs the finished row; no new byte is taken until then. delimiters
// and skipped bytes do not enter the row. a byte that closes a word or the text
// passes through ST_DONE to fold the word distance into the best result.
// the result is set once a last byte has been processed and is held in an
// output register until taken; while it waits the input is not ready.
// reset clears all text state and sets needle_length 1, threshold -1.
// after the last byte, the text state returns to its reset values.
module fuzzy_word_search_unit
    import fws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fws_stream_if.sink   in_ch,
    fws_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
`include "fuzzy_word_search_unit_assert.svh"
    logic [NEEDLE_MAX*8-1:0] needle_reg;
    logic [5:0]  nlen_reg;
    logic signed [6:0] good_reg;
    logic        strict_reg;

    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  wlen_reg, wlen_next;
    logic        inword_reg, inword_next, skip_reg, skip_next;
    logic [5:0]  best_reg, best_next;
    logic        any_reg, any_next, stop_reg, stop_next;
    logic        fin_reg, fin_next, last_reg, last_next;
    logic [7:0]  ov_reg, ov_next;
    logic        ovalid_reg, ovalid_next;
    logic        start_reg, start_next;

    logic [LW-1:0] alen;
    logic [7:0]  c, first;
    logic        last, dl, acc, row_en, fire;
    cell_ctl_t   ctl;
    logic [DW-1:0] row_dist;
    logic [5:0]  nb;
    logic        na;

    assign alen = (nlen_reg > 6'(NEEDLE_MAX)) ? LW'(NEEDLE_MAX) : LW'(nlen_reg);
    assign c = in_ch.data[7:0];
    assign last = in_ch.data[8];
    assign first = needle_reg[7:0];
    assign dl = is_delim(c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg <= '0;
            nlen_reg <= 6'd1;
            good_reg <= -7'sd1;
            strict_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_NEEDLE_LO:     needle_reg[63:0] <= cfg_data;
                REG_NEEDLE_MID_LO: needle_reg[127:64] <= cfg_data;
                REG_NEEDLE_MID_HI: needle_reg[191:128] <= cfg_data;
                REG_NEEDLE_HI:     needle_reg[255:192] <= cfg_data;
                REG_NEEDLE_LEN:    nlen_reg <= cfg_data[5:0];
                REG_GOOD:          good_reg <= signed'(cfg_data[6:0]);
                REG_STRICT:        strict_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    fws_row u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (row_en),
        .needle   (needle_reg),
        .ctl      (ctl),
        .sel      (alen),
        .row_dist (row_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            wlen_reg <= '0;
            inword_reg <= 1'b0;
            skip_reg <= 1'b0;
            best_reg <= '0;
            any_reg <= 1'b0;
            stop_reg <= 1'b0;
            fin_reg <= 1'b0;
            last_reg <= 1'b0;
            ov_reg <= '0;
            ovalid_reg <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            wlen_reg <= wlen_next;
            inword_reg <= inword_next;
            skip_reg <= skip_next;
            best_reg <= best_next;
            any_reg <= any_next;
            stop_reg <= stop_next;
            fin_reg <= fin_next;
            last_reg <= last_next;
            ov_reg <= ov_next;
            ovalid_reg <= ovalid_next;
            start_reg <= start_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        wlen_next = wlen_reg;
        inword_next = inword_reg;
        skip_next = skip_reg;
        best_next = best_reg;
        any_next = any_reg;
        stop_next = stop_reg;
        fin_next = fin_reg;
        last_next = last_reg;
        ov_next = ov_reg;
        ovalid_next = ovalid_reg;
        start_next = start_reg;
        ctl = '{valid: 1'b0, start: 1'b0, ch: c};
        row_en = 1'b0;
        fire = 1'b0;
        nb = best_reg;
        na = any_reg;
        in_ch.ready = 1'b0;
        acc = 1'b0;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !ovalid_reg;
                acc = in_ch.valid && in_ch.ready;
                if (acc)
                begin
                    last_next = last;
                    fin_next = inword_reg && (dl || last);
                    if (!dl)
                    begin
                        if (!inword_reg)
                        begin
                            inword_next = 1'b1;
                            wlen_next = '0;
                            start_next = 1'b1;
                            skip_next = stop_reg ||
                                (strict_reg && is_alpha(first) &&
                                 to_lower(c) != to_lower(first));
                        end
                        else
                            start_next = 1'b0;
                        if (!skip_next)
                        begin
                            if (wlen_next >= 6'(NEEDLE_MAX))
                                skip_next = 1'b1;
                            else
                            begin
                                ctl = '{valid: 1'b1, start: start_next, ch: c};
                                row_en = 1'b1;
                                wlen_next = wlen_next + 6'd1;
                                fin_next = dl || last;
                                cnt_next = 6'(alen);
                                state_next = ST_RUN;
                            end
                        end
                    end
                    if (state_next == ST_IDLE)
                        state_next = (fin_next || last) ? ST_DONE : ST_IDLE;
                end
            end
            ST_RUN:
            begin
                row_en = 1'b1;
                ctl = '{valid: 1'b0, start: 1'b0, ch: 8'd0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg <= 6'd1)
                    state_next = (fin_reg || last_reg) ? ST_DONE : ST_IDLE;
            end
            ST_DONE:
            begin
                if (fin_reg)
                begin
                    if (!skip_reg)
                    begin
                        if (!any_reg || row_dist < best_reg)
                            nb = row_dist;
                        na = 1'b1;
                        if ($signed({1'b0, nb}) <= good_reg)
                            stop_next = 1'b1;
                    end
                    inword_next = 1'b0;
                end
                best_next = nb;
                any_next = na;
                fin_next = 1'b0;
                if (last_reg)
                begin
                    fire = 1'b1;
                    ov_next = {na && ($signed({1'b0, nb}) <= good_reg),
                               na, na ? nb : 6'd0};
                    ovalid_next = 1'b1;
                    best_next = '0;
                    any_next = 1'b0;
                    stop_next = 1'b0;
                    inword_next = 1'b0;
                    skip_next = 1'b0;
                    wlen_next = '0;
                    last_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = ov_reg;

    `FWS_ASSERT_NEXT(a_fire_valid, clk, rst_n, fire, out_ch.valid)
    `FWS_ASSERT_IMPL(a_no_intake_busy, clk, rst_n,
        (state_reg != ST_IDLE || ovalid_reg) |-> !in_ch.ready)
    `FWS_ASSERT_IMPL(a_scored_range, clk, rst_n,
        (out_ch.valid && !out_ch.data[6]) |-> (out_ch.data[5:0] == 6'd0))
endmodule

// File: sv/fws_cell.sv
// one needle cell of the distance row: holds one row entry
// depends on fws_pkg
module fws_cell
    import fws_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [LW-1:0]   idx,
    input  logic [7:0]      needle_ch,
    input  cell_ctl_t       ctl_in,
    input  logic [DW-1:0]   left_new,
    input  logic [DW-1:0]   left_old,
    output cell_ctl_t       ctl_out,
    output logic [DW-1:0]   val_new,
    output logic [DW-1:0]   val_old
);
    logic [DW-1:0] d_reg, d_next, prev_reg;
    cell_ctl_t     ctl_reg;
    logic [DW-1:0] up, a, b, c;

    always_comb
    begin
        up = ctl_in.start ? DW'(idx) : d_reg;
        a = up + DW'(1);
        b = left_new + DW'(1);
        c = left_old + DW'((ctl_in.ch != needle_ch) ? 1'b1 : 1'b0);
        d_next = a;
        if (b < d_next) d_next = b;
        if (c < d_next) d_next = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= DW'(idx);
            ctl_reg <= '0;
            prev_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
            if (ctl_in.valid)
            begin
                prev_reg <= up;
                d_reg <= d_next;
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign val_new = d_reg;
    assign val_old = prev_reg;
endmodule

// File: sv/fws_row.sv
// chain of needle cells with a skewed wavefront, one cell per needle byte
// depends on fws_pkg and fws_cell
module fws_row
    import fws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [NEEDLE_MAX*8-1:0]  needle,
    input  cell_ctl_t                ctl,
    input  logic [LW-1:0]            sel,
    output logic [DW-1:0]            row_dist
);
    cell_ctl_t     ctl_c [NEEDLE_MAX+1];
    logic [DW-1:0] vn [NEEDLE_MAX+1];
    logic [DW-1:0] vo [NEEDLE_MAX+1];
    logic [DW-1:0] rv [NEEDLE_MAX+1];
    logic [DW-1:0] col0_reg;

    // column zero: distance of empty needle prefix equals word length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col0_reg <= '0;
        else if (en && ctl.valid)
            col0_reg <= (ctl.start ? '0 : col0_reg) + DW'(1);
    end

    assign ctl_c[0] = ctl;
    assign vn[0] = ctl.start ? DW'(1) : col0_reg + DW'(1);
    assign vo[0] = ctl.start ? '0 : col0_reg;
    assign rv[0] = col0_reg;

    for (genvar j = 0; j < NEEDLE_MAX; j++)
    begin : g_cell
        fws_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .idx       (LW'(j + 1)),
            .needle_ch (needle[j*8 +: 8]),
            .ctl_in    (ctl_c[j]),
            .left_new  (vn[j]),
            .left_old  (vo[j]),
            .ctl_out   (ctl_c[j+1]),
            .val_new   (vn[j+1]),
            .val_old   (vo[j+1])
        );
        assign rv[j+1] = vn[j+1];
    end

    assign row_dist = rv[sel];
endmodule

// File: test/fuzzy_word_search_unit_tb.sv
// self-checking testbench for fuzzy_word_search_unit: streams texts of words
// near a random needle under random stalls and checks each text's result
// depends on fws_pkg, fws_stream_if and fuzzy_word_search_unit
`timescale 1ns / 100ps

module fuzzy_word_search_unit_tb
    import fws_pkg::*;
();

    class search_scoreboard;
        logic [7:0]  needle [0:31];
        int          pat_len;
        int          threshold;
        bit          strict;
        int          row [0:32];
        int          word_len;
        bit          in_word;
        bit          skip;
        int          best;
        bit          scored;
        bit          stopped;
        logic [7:0]  results_due [$];
        int          errors;

        function new();
            foreach (needle[i]) needle[i] = 8'h00;
            pat_len = 1;
            threshold = -1;
            strict = 0;
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            for (int i = 0; i <= 32; i++) row[i] = i;
            word_len = 0;
            in_word = 0;
            skip = 0;
            best = 0;
            scored = 0;
            stopped = 0;
        endfunction

        function void set_reg(reg_idx_t r, logic [63:0] v);
            case (r)
                REG_NEEDLE_LO, REG_NEEDLE_MID_LO, REG_NEEDLE_MID_HI, REG_NEEDLE_HI:
                begin
                    for (int k = 0; k < 8; k++) needle[int'(r) * 8 + k] = v[k*8 +: 8];
                end
                REG_NEEDLE_LEN: pat_len = (v[5:0] > 32) ? 32 : int'(v[5:0]);
                REG_GOOD: threshold = int'($signed(v[6:0]));
                REG_STRICT: strict = v[0];
                default: ;
            endcase
        endfunction

        function bit word_break(logic [7:0] c);
            return c == 8'h20 || c == 8'h2c || c == 8'h2e || c == 8'h3b ||
                   c == 8'h2d || c == 8'h0a || c == 8'h00;
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
        endfunction

        function void advance_row(logic [7:0] c);
            int diag;
            int up;
            int v;
            diag = row[0];
            row[0] = diag + 1;
            for (int j = 0; j < pat_len; j++) begin
                up = row[j + 1];
                v = diag + ((c != needle[j]) ? 1 : 0);
                if (up + 1 < v) v = up + 1;
                if (row[j] + 1 < v) v = row[j] + 1;
                diag = up;
                row[j + 1] = v;
            end
        endfunction

        function void note_byte(logic [7:0] c, bit last);
            bit brk;
            logic [7:0] f;
            brk = word_break(c);
            f = needle[0];
            if (!brk) begin
                if (!in_word) begin
                    in_word = 1;
                    word_len = 0;
                    for (int i = 0; i <= 32; i++) row[i] = i;
                    skip = stopped;
                    if (strict && lower(f) >= 8'h61 && lower(f) <= 8'h7a &&
                        lower(c) != lower(f))
                        skip = 1;
                end
                if (!skip) begin
                    if (word_len >= 32) skip = 1;
                    else
                    begin
                        advance_row(c);
                        word_len++;
                    end
                end
            end
            if (in_word && (brk || last)) begin
                if (!skip) begin
                    if (!scored || row[pat_len] < best) best = row[pat_len];
                    scored = 1;
                    if (best <= threshold) stopped = 1;
                end
                in_word = 0;
            end
            if (last) begin
                results_due.push_back({scored && best <= threshold, scored,
                                       scored ? best[5:0] : 6'd0});
                clear_text();
            end
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (results_due.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got[5:0] !== want[5:0]) begin
                $error("best_distance expected %0d actual %0d", want[5:0], got[5:0]);
                errors++;
            end
            if (got[6] !== want[6]) begin
                $error("word_scored expected %0b actual %0b", want[6], got[6]);
                errors++;
            end
            if (got[7] !== want[7]) begin
                $error("within_good expected %0b actual %0b", want[7], got[7]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          bytes_sent;
    logic [7:0]  needle_text [0:31];
    int          cur_len;

    fws_stream_if #(9) in_if ();
    fws_stream_if #(8) out_if ();
    search_scoreboard sb;

    fuzzy_word_search_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if.sink),
        .out_ch   (out_if.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, checks each result beat before its accepting edge
    initial
    begin
        int hold;
        bit busy_spell;
        out_if.ready = 0;
        hold = 0;
        busy_spell = 0;
        @(posedge clk);
        forever
        begin
            @(negedge clk);
            if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
            @(posedge clk);
            if (hold > 0) hold--;
            else
            begin
                busy_spell = ($urandom_range(0, 3) == 0);
                hold = busy_spell ? pick_gap() : $urandom_range(5, 30);
            end
            out_if.ready <= busy_spell ? 1'b0 : 1'b1;
        end
    end

    task automatic write_reg(reg_idx_t r, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(r, v);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_byte(logic [7:0] c, bit last);
        int gap;
        in_if.valid <= 1'b1;
        in_if.data <= {last, c};
        @(negedge clk);
        while (!in_if.ready) @(negedge clk);
        @(posedge clk);
        sb.note_byte(c, last);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // all writes at idle, then the enable drops
    task automatic configure(int len, int thr, bit strict_mode);
        logic [63:0] w;
        for (int q = 0; q < 4; q++) begin
            for (int k = 0; k < 8; k++) w[k*8 +: 8] = needle_text[q*8 + k];
            write_reg(reg_idx_t'(q), w);
        end
        write_reg(REG_NEEDLE_LEN, 64'(len));
        write_reg(REG_GOOD, 64'(7'(thr)));
        write_reg(REG_STRICT, 64'(strict_mode));
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_len = len;
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (sb.word_break(c));
        return c;
    endfunction

    function automatic logic [7:0] break_char();
        logic [7:0] seps [7] = '{8'h20, 8'h2c, 8'h2e, 8'h3b, 8'h2d, 8'h0a, 8'h00};
        return seps[$urandom_range(0, 6)];
    endfunction

    // a word near the needle, or noise, or an overlong word
    task automatic send_word(bit last_word);
        logic [7:0] w [$];
        int kind;
        int edits;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            for (int i = 0; i < cur_len; i++) w.push_back(needle_text[i]);
            edits = $urandom_range(0, 3);
            repeat (edits) begin
                case ($urandom_range(0, 3))
                    0: if (w.size() > 1) w.delete($urandom_range(0, w.size() - 1));
                    1: w.insert($urandom_range(0, w.size()), word_char());
                    2: w[$urandom_range(0, w.size() - 1)] = word_char();
                    default: w[0] = w[0] ^ 8'h20;
                endcase
            end
        end
        else if (kind < 9) begin
            repeat ($urandom_range(1, 6)) w.push_back(word_char());
        end
        else
        begin
            repeat ($urandom_range(31, 38)) w.push_back(word_char());
        end
        foreach (w[i]) begin
            if (sb.word_break(w[i])) w[i] = 8'h41;
            send_byte(w[i], last_word && i == w.size() - 1);
        end
    endtask

    task automatic send_text();
        int words;
        bit tail_break;
        words = $urandom_range(1, 6);
        tail_break = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) send_byte(break_char(), 1'b0);
        for (int i = 0; i < words; i++) begin
            send_word(i == words - 1 && !tail_break);
            if (i != words - 1 || tail_break) begin
                repeat ($urandom_range(0, 1)) send_byte(break_char(), 1'b0);
                send_byte(break_char(), i == words - 1);
            end
        end
    endtask

    function automatic void make_needle(int kind);
        for (int i = 0; i < 32; i++) begin
            if (kind == 0) needle_text[i] = 8'($urandom_range(8'h61, 8'h7a));
            else if (kind == 1) needle_text[i] = 8'($urandom_range(8'h41, 8'h5a));
            else needle_text[i] = 8'($urandom_range(0, 255));
        end
    endfunction

    initial
    begin
        int lens [4] = '{1, 32, 2, 5};
        int thrs [4] = '{-1, 0, 32, 2};
        int phase;
        sb = new();
        bytes_sent = 0;
        cur_len = 1;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_NEEDLE_LO;
        cfg_data = '0;
        in_if.valid = 0;
        in_if.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: a single NUL needle byte
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h2d, 1'b1);
        drain();

        // strict mode against "Cat", overlong word, space, comma, period, semicolon and newline breaks
        make_needle(0);
        needle_text[0] = 8'h43;
        needle_text[1] = 8'h61;
        needle_text[2] = 8'h74;
        configure(3, 1, 1'b1);
        send_byte(8'h63, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h54, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h2c, 1'b0);
        send_byte(8'h2e, 1'b0);
        send_byte(8'h3b, 1'b0);
        send_byte(8'h0a, 1'b1);
        drain();
        configure(3, -1, 1'b0);
        repeat (33) send_byte(8'h78, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'h61, 1'b1);
        drain();

        phase = 0;
        while (bytes_sent < 1350) begin
            make_needle($urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1));
            configure(phase < 8 ? lens[phase % 4] : $urandom_range(1, 32),
                      phase < 8 ? thrs[phase / 2 % 4] : $urandom_range(0, 33) - 1,
                      phase % 3 == 1);
            repeat ($urandom_range(4, 10))
                if (bytes_sent < 1350) send_text();
            // sender waits out every pending result
            drain();
            phase++;
        end

        in_if.valid <= 1'b0;
        drain();
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
